// ----- hdl/chpl_pkg.sv -----
// ----------------------------------------------------------------------------
// chpl_pkg
// Shared constants, log table and fixed-point helpers for the COST231-Hata
// path loss pipeline. All log and loss values are signed Q16.
// ----------------------------------------------------------------------------
package chpl_pkg;

   localparam int LOG_TABLE_BITS = 8;
   localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
   localparam int LOG_ARG_W      = 18;
   localparam int LOG_POS_W      = 5;
   localparam int LOG_OUT_W      = 20;
   localparam int NUM_STAGES     = 7;

   localparam logic [1:0] ENV_URBAN    = 2'd1;
   localparam logic [1:0] ENV_SUBURBAN = 2'd2;
   localparam logic [1:0] ENV_OPEN     = 2'd3;

   localparam logic [10:0] FREQ_HI_LIMIT = 11'd1500;

   localparam logic signed [31:0] Q_ONE     = 32'sd65536;
   localparam logic signed [31:0] K_C0_LO   = 32'sd4558029;
   localparam logic signed [31:0] K_CF_LO   = 32'sd1714422;
   localparam logic signed [31:0] K_C0_HI   = 32'sd3034317;
   localparam logic signed [31:0] K_CF_HI   = 32'sd2221670;
   localparam logic signed [31:0] K_HB      = 32'sd905708;
   localparam logic signed [31:0] K_D0      = 32'sd2942566;
   localparam logic signed [31:0] K_D1      = 32'sd429261;
   localparam logic signed [31:0] K_U_A     = 32'sd209715;
   localparam logic signed [31:0] K_U_B     = 32'sd325714;
   localparam logic signed [31:0] K_S_A     = 32'sd543293;
   localparam logic signed [31:0] K_S_B     = 32'sd72090;
   localparam logic signed [31:0] K_O_A     = 32'sd72090;
   localparam logic signed [31:0] K_O_B     = 32'sd45875;
   localparam logic signed [31:0] K_O_C     = 32'sd102236;
   localparam logic signed [31:0] K_O_D     = 32'sd52429;
   localparam logic [14:0]        K_LOG10_2 = 15'd19728;

   localparam logic [9:0]  MUL_SUB = 10'd154;
   localparam logic [10:0] MUL_URB = 11'd1175;

   // Exact floor division by ten for any unsigned 32-bit value.
   localparam logic [63:0]        DIV10_RECIP  = 64'hCCCCCCCD;
   localparam int                 DIV10_SHIFT  = 35;
   localparam logic signed [39:0] DIV10_BIAS   = 40'sd83886085;
   localparam logic signed [31:0] DIV10_OFFSET = 32'sd8388608;

   typedef logic [16:0] log_tab_type [TABLE_SIZE];

   typedef struct packed {
      logic [1:0] env;
      logic       hi;
      logic [6:0] hm;
   } side_type;

   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] m;
      logic [17:0] r;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         m = 64'(TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
         r = '0;
         for (int k = 0; k < 17; k++) begin
            m = (m * m) >> 30;
            r = {r[16:0], 1'b0};
            if (m >= 64'h8000_0000) begin
               m = m >> 1;
               r[0] = 1'b1;
            end
         end
         tab[i] = 17'((r + 18'd1) >> 1);
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd32768;
      return p[47:16];
   endfunction

endpackage

// ----- hdl/cost231_hata_path_loss_unit.sv -----
// ----------------------------------------------------------------------------
// cost231_hata_path_loss_unit
// COST231-Hata path loss for one link per beat, fully pipelined.
//
// The req_ channel carries one link per beat (frequency, antenna heights and
// distance); the rsp_ channel returns the loss in sixteenths of a dB,
// saturated to 0..4095. csr_wen writes the environment register from
// csr_wdata; it should change only while no beat is in flight.
// Throughput is one beat per cycle while rsp_tready does not stall, set by a
// seven-stage pipeline with at most one multiplier level per stage. Each stage
// advances when it is empty or the stage after it advances, so a stalled
// rsp_tready fills empty stages first and then holds every beat in place;
// nothing is lost or repeated.
// Reset clears all stage valid bits and sets the environment to urban.
// ----------------------------------------------------------------------------
module cost231_hata_path_loss_unit
   import chpl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [1:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [10:0] freq_mhz, [22:11] base_height_dm, [29:23] mobile_height_dm,
   // [46:30] distance_m, [47] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [11:0] loss_db_q4, [15:12] zero
   output logic [15:0] rsp_tdata
);

   logic [1:0]            env_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   logic [10:0] f_in;
   logic [6:0]  hm_in;
   logic [17:0] r_in;

   logic [10:0] a_f_ff;
   logic [11:0] a_hb_ff;
   logic [16:0] a_d_ff;
   logic [17:0] a_r_ff;
   side_type    a_side_ff, b_side_ff, c_side_ff, d_side_ff, e_side_ff, f_side_ff;

   logic [LOG_OUT_W-1:0] lg_f, lg_hb, lg_d, lg_r;

   logic signed [31:0] lf, lb, ld, lr, cf;
   logic signed [31:0] d_cflf_ff, d_hblb_ff, d_d1lb_ff, d_ld_ff, d_sq_ff;
   logic signed [31:0] d_oalf_ff, d_oclf_ff;

   logic signed [31:0] ka, e_t;
   logic signed [31:0] e_dterm_ff, e_ma_ff, e_cflf_ff, e_hblb_ff, e_oclf_ff;
   logic signed [39:0] e_thm_ff;

   logic [31:0]        f_u;
   logic [63:0]        f_prod;
   logic [28:0]        f_quo_ff;
   logic signed [31:0] f_dterm_ff, f_ma_ff, f_cflf_ff, f_hblb_ff, f_oclf_ff;

   logic signed [33:0] ch, cc, c0, loss;
   logic signed [33:0] q4_full;
   logic [11:0]        loss_in;
   logic [11:0]        loss_ff;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {4'd0, loss_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff   <= ENV_URBAN;
         valid_ff <= '0;
      end else begin
         if (csr_wen) begin
            env_ff <= csr_wdata;
         end
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_comb begin
      f_in  = req_tdata[10:0];
      hm_in = req_tdata[29:23];
      r_in  = (env_ff == ENV_SUBURBAN) ? 18'(hm_in) * 18'(MUL_SUB)
                                       : 18'(hm_in) * 18'(MUL_URB);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_f_ff        <= f_in;
         a_hb_ff       <= req_tdata[22:11];
         a_d_ff        <= req_tdata[46:30];
         a_r_ff        <= r_in;
         a_side_ff.env <= env_ff;
         a_side_ff.hi  <= (f_in > FREQ_HI_LIMIT);
         a_side_ff.hm  <= hm_in;
      end
      if (en[1]) begin
         b_side_ff <= a_side_ff;
      end
      if (en[2]) begin
         c_side_ff <= b_side_ff;
      end
   end

   chpl_log u_log_f (
      .clock     (clock),
      .stage1_en (en[1]),
      .stage2_en (en[2]),
      .arg       (LOG_ARG_W'(a_f_ff)),
      .log10_q16 (lg_f)
   );

   chpl_log u_log_hb (
      .clock     (clock),
      .stage1_en (en[1]),
      .stage2_en (en[2]),
      .arg       (LOG_ARG_W'(a_hb_ff)),
      .log10_q16 (lg_hb)
   );

   chpl_log u_log_d (
      .clock     (clock),
      .stage1_en (en[1]),
      .stage2_en (en[2]),
      .arg       (LOG_ARG_W'(a_d_ff)),
      .log10_q16 (lg_d)
   );

   chpl_log u_log_r (
      .clock     (clock),
      .stage1_en (en[1]),
      .stage2_en (en[2]),
      .arg       (a_r_ff),
      .log10_q16 (lg_r)
   );

   always_comb begin
      lf = 32'(signed'({1'b0, lg_f}));
      lb = 32'(signed'({1'b0, lg_hb})) - Q_ONE;
      ld = 32'(signed'({1'b0, lg_d})) - 3 * Q_ONE;
      lr = 32'(signed'({1'b0, lg_r})) - 3 * Q_ONE;
      cf = c_side_ff.hi ? K_CF_HI : K_CF_LO;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d_cflf_ff <= mulq(cf, lf);
         d_hblb_ff <= mulq(K_HB, lb);
         d_d1lb_ff <= mulq(K_D1, lb);
         d_ld_ff   <= ld;
         d_sq_ff   <= mulq(lr, lr);
         d_oalf_ff <= mulq(K_O_A, lf);
         d_oclf_ff <= mulq(K_O_C, lf);
         d_side_ff <= c_side_ff;
      end
   end

   always_comb begin
      ka  = (d_side_ff.env == ENV_SUBURBAN) ? K_S_A : K_U_A;
      e_t = d_oalf_ff - K_O_B;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         e_dterm_ff <= mulq(K_D0 - d_d1lb_ff, d_ld_ff);
         e_ma_ff    <= mulq(ka, d_sq_ff);
         e_thm_ff   <= 40'(e_t) * 40'(signed'({1'b0, d_side_ff.hm}));
         e_cflf_ff  <= d_cflf_ff;
         e_hblb_ff  <= d_hblb_ff;
         e_oclf_ff  <= d_oclf_ff;
         e_side_ff  <= d_side_ff;
      end
   end

   always_comb begin
      f_u    = 32'(e_thm_ff + DIV10_BIAS);
      f_prod = 64'(f_u) * DIV10_RECIP;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         f_quo_ff   <= f_prod[63:DIV10_SHIFT];
         f_dterm_ff <= e_dterm_ff;
         f_ma_ff    <= e_ma_ff;
         f_cflf_ff  <= e_cflf_ff;
         f_hblb_ff  <= e_hblb_ff;
         f_oclf_ff  <= e_oclf_ff;
         f_side_ff  <= e_side_ff;
      end
   end

   always_comb begin
      case (f_side_ff.env)
         ENV_SUBURBAN: begin
            ch = 34'(f_ma_ff) - 34'(K_S_B);
            cc = 34'sd0;
         end
         ENV_OPEN: begin
            ch = 34'(signed'({1'b0, f_quo_ff})) - 34'(DIV10_OFFSET)
               - 34'(f_oclf_ff) + 34'(K_O_D);
            cc = -34'(Q_ONE) * 34'sd3;
         end
         default: begin
            ch = 34'(f_ma_ff) - 34'(K_U_B);
            cc = 34'(Q_ONE) * 34'sd3;
         end
      endcase
      c0 = f_side_ff.hi ? 34'(K_C0_HI) : 34'(K_C0_LO);
      loss = c0 + 34'(f_cflf_ff) - 34'(f_hblb_ff) - ch + 34'(f_dterm_ff) + cc;
      q4_full = (loss + 34'sd2048) >>> 12;
      if (q4_full < 0) begin
         loss_in = 12'd0;
      end else if (q4_full > 34'sd4095) begin
         loss_in = 12'd4095;
      end else begin
         loss_in = q4_full[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         loss_ff <= loss_in;
      end
   end

endmodule

// ----- hdl/chpl_log.sv -----
// ----------------------------------------------------------------------------
// chpl_log
// Two-stage log10 unit: leading-one search and table lookup into a Q16 log2,
// then scaling by log10(2) with rounding. A zero argument acts as one.
// ----------------------------------------------------------------------------
module chpl_log
   import chpl_pkg::*;
(
   input  logic                 clock,
   input  logic                 stage1_en,
   input  logic                 stage2_en,
   input  logic [LOG_ARG_W-1:0] arg,
   output logic [LOG_OUT_W-1:0] log10_q16
);

   logic [LOG_ARG_W-1:0]                x;
   logic [LOG_POS_W-1:0]                pos;
   logic [LOG_ARG_W+LOG_TABLE_BITS-1:0] shifted;
   logic [LOG_TABLE_BITS-1:0]           idx;
   logic [LOG_POS_W+16:0]               l2_in;
   logic [LOG_POS_W+16:0]               l2_ff;
   logic [LOG_POS_W+32:0]               scaled;
   logic [LOG_OUT_W-1:0]                log_in;
   logic [LOG_OUT_W-1:0]                log_ff;

   always_comb begin
      x = (arg == '0) ? LOG_ARG_W'(1) : arg;
      pos = '0;
      for (int i = 1; i < LOG_ARG_W; i++) begin
         if (x[i]) begin
            pos = LOG_POS_W'(i);
         end
      end
      shifted = {x, {LOG_TABLE_BITS{1'b0}}} >> pos;
      idx = shifted[LOG_TABLE_BITS-1:0];
      l2_in = (LOG_POS_W+17)'({pos, 16'd0}) + (LOG_POS_W+17)'(LOG_TAB[idx]);
      scaled = (LOG_POS_W+33)'(l2_ff) * (LOG_POS_W+33)'(K_LOG10_2)
             + (LOG_POS_W+33)'(32768);
      log_in = LOG_OUT_W'(scaled >> 16);
   end

   always_ff @(posedge clock) begin
      if (stage1_en) begin
         l2_ff <= l2_in;
      end
      if (stage2_en) begin
         log_ff <= log_in;
      end
   end

   assign log10_q16 = log_ff;

endmodule

// ----- bench/cost231_hata_path_loss_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cost231_hata_path_loss_unit_tb
// Drives link beats into the path loss unit under every environment setting,
// predicts each loss in fixed point and checks responses in order, with
// random idling on both channels and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module cost231_hata_path_loss_unit_tb
   import chpl_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;
   int error_count = 0;

   cost231_hata_path_loss_unit DUT (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint round_div(longint p, longint den);
      longint half;
      half = den / 2;
      if (p >= 0) return (p + half) / den;
      return -((-p + den - 1 - half) / den);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_div(a * b, 65536);
   endfunction

   function automatic longint frac_log2(int unsigned idx);
      longint unsigned m;
      longint unsigned r;
      m = longint'((1 << LOG_TABLE_BITS) + idx) << (30 - LOG_TABLE_BITS);
      r = 0;
      for (int k = 0; k < 17; k++) begin
         m = (m * m) >> 30;
         r = r << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            r = r | 1;
         end
      end
      return longint'((r + 1) >> 1);
   endfunction

   function automatic longint lg10(int unsigned x);
      int unsigned pos;
      int unsigned fr;
      int unsigned idx;
      longint l2;
      pos = 0;
      if (x == 0) x = 1;
      while (pos < 31 && (x >> (pos + 1)) != 0) pos++;
      fr = x - (32'd1 << pos);
      if (pos >= LOG_TABLE_BITS) idx = fr >> (pos - LOG_TABLE_BITS);
      else idx = fr << (LOG_TABLE_BITS - pos);
      idx = idx & ((1 << LOG_TABLE_BITS) - 1);
      l2 = longint'(pos) * 65536 + frac_log2(idx);
      return round_div(l2 * 19728, 65536);
   endfunction

   function automatic logic [11:0] path_loss_q4(logic [1:0] env, logic [47:0] link);
      int unsigned f, hb, hm, d;
      longint lf, lb, ld, c0, cf, ch, cc, lr, t, loss, q4;
      f = link[10:0];
      hb = link[22:11];
      hm = link[29:23];
      d = link[46:30];
      lf = lg10(f);
      lb = lg10(hb) - 65536;
      ld = lg10(d) - 3 * 65536;
      c0 = K_C0_LO;
      cf = K_CF_LO;
      if (f > 1500) begin
         c0 = K_C0_HI;
         cf = K_CF_HI;
      end
      if (env == ENV_SUBURBAN) begin
         cc = 0;
         lr = lg10(154 * hm) - 3 * 65536;
         ch = qmul(K_S_A, qmul(lr, lr)) - K_S_B;
      end else if (env == ENV_OPEN) begin
         cc = -3;
         t = qmul(K_O_A, lf) - K_O_B;
         ch = round_div(t * longint'(hm), 10) - qmul(K_O_C, lf) + K_O_D;
      end else begin
         cc = 3;
         lr = lg10(1175 * hm) - 3 * 65536;
         ch = qmul(K_U_A, qmul(lr, lr)) - K_U_B;
      end
      loss = c0 + qmul(cf, lf) - qmul(K_HB, lb) - ch
           + qmul(K_D0 - qmul(K_D1, lb), ld) + cc * 65536;
      q4 = round_div(loss, 4096);
      if (q4 < 0) q4 = 0;
      if (q4 > 4095) q4 = 4095;
      return q4[11:0];
   endfunction

   class loss_scoreboard;
      logic [15:0] pending_loss[$];
      logic [1:0]  env = ENV_URBAN;

      function void note_link(logic [47:0] link);
         pending_loss.push_back({4'd0, path_loss_q4(env, link)});
      endfunction

      function void check_loss(logic [15:0] got);
         logic [15:0] want;
         if (pending_loss.size() == 0) begin
            $display("%0t: unexpected loss beat, expected none, actual %0d", $time, got);
            error_count++;
            return;
         end
         want = pending_loss.pop_front();
         if (got !== want) begin
            $display("%0t: loss mismatch, expected %0d, actual %0d", $time, want, got);
            error_count++;
         end
      endfunction
   endclass

   loss_scoreboard sb = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_link(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_loss(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [47:0] pack_link(int f, int hb, int hm, int d);
      return {1'b0, 17'(d), 7'(hm), 12'(hb), 11'(f)};
   endfunction

   task automatic send_link(logic [47:0] link);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= link;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_loss.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 3) @(posedge clock);
   endtask

   task automatic write_env(logic [1:0] env);
      csr_wen <= 1'b1;
      csr_wdata <= env;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.env = env;
      @(posedge clock);
   endtask

   task automatic hold_receiver(int cycles);
      hold_off = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off = 1'b0;
   endtask

   function automatic logic [47:0] random_link();
      case ($urandom_range(9))
         0: return 48'($urandom) & 48'h7FFF_FFFF_FFFF;
         1: return pack_link($urandom_range(150, 2000), $urandom_range(10, 3000),
                             $urandom_range(10, 100), $urandom_range(100, 1000));
         default: return pack_link($urandom_range(150, 2000), $urandom_range(10, 3000),
                                   $urandom_range(10, 100), $urandom_range(100, 100000));
      endcase
   endfunction

   task automatic run_directed();
      send_link(pack_link(150, 10, 10, 100));
      send_link(pack_link(2000, 3000, 100, 100000));
      send_link(pack_link(1500, 300, 15, 1000));
      send_link(pack_link(1501, 300, 15, 1000));
      send_link(pack_link(0, 0, 0, 0));
      send_link(pack_link(2047, 4095, 127, 131071));
      send_link(pack_link(1, 1, 1, 1));
      send_link(pack_link(2047, 1, 127, 131071));
      send_link(pack_link(150, 4095, 1, 1));
      send_link(pack_link(900, 500, 20, 5000));
      send_link(48'h7FFF_FFFF_FFFF);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_link(random_link());
   endtask

   initial begin
      logic [1:0] env_seq[5] = '{ENV_URBAN, ENV_SUBURBAN, ENV_OPEN, 2'd0, ENV_URBAN};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int e = 0; e < 5; e++) begin
         write_env(env_seq[e]);
         run_directed();
         for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 15 : 0;
            run_random(100);
         end
         if (e == 0) begin
            fork
               hold_receiver(200);
            join_none
         end
         run_random(30);
         go_idle();
      end
      go_idle();
      if (error_count == 0) $display("cost231_hata_path_loss_unit verification clean");
      else $display("cost231_hata_path_loss_unit verification failed");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("cost231_hata_path_loss_unit verification failed");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/chpl_pkg.sv
hdl/chpl_log.sv
hdl/cost231_hata_path_loss_unit.sv
bench/cost231_hata_path_loss_unit_tb.sv
